@@ design/mtep_pkg.sv @@
// ----------------------------------------------------------------------------
// mtep_pkg
// shared types and constants for the midi track event parser
// ----------------------------------------------------------------------------
`default_nettype none

package mtep_pkg;

   // longest variable-length quantity accepted, in bytes (1 to 4)
   localparam int VLV_MAX_BYTES = 4;
   // default width of the per-track event counter
   localparam int EVENT_COUNT_BITS = 16;

   // midi byte boundaries
   localparam logic [7:0] DATA_MAX    = 8'h7F;
   localparam logic [7:0] CHAN3_LO    = 8'h80;
   localparam logic [7:0] CHAN3_HI    = 8'hBF;
   localparam logic [7:0] CHAN2_LO    = 8'hC0;
   localparam logic [7:0] CHAN2_HI    = 8'hDF;
   localparam logic [7:0] PITCH_LO    = 8'hE0;
   localparam logic [7:0] PITCH_HI    = 8'hEF;
   localparam logic [7:0] META_STATUS = 8'hFF;
   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] SYSEX_ESC   = 8'hF7;
   localparam logic [7:0] VLV_PAYLOAD = 8'b01111111;

   // event kinds
   localparam logic [1:0] KIND_CHAN3 = 2'd0;
   localparam logic [1:0] KIND_CHAN2 = 2'd1;
   localparam logic [1:0] KIND_META  = 2'd2;
   localparam logic [1:0] KIND_SYSEX = 2'd3;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_NO_RUNNING = 3'd1;
   localparam logic [2:0] ERR_BAD_STATUS = 3'd2;
   localparam logic [2:0] ERR_VLV_LONG   = 3'd3;
   localparam logic [2:0] ERR_TRUNCATED  = 3'd4;

   // parse phase
   typedef enum logic [4:0] {
      PH_DELTA  = 5'b00001,
      PH_STATUS = 5'b00010,
      PH_MTYPE  = 5'b00100,
      PH_LEN    = 5'b01000,
      PH_DATA   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       track_first;
      logic       track_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [27:0] delta_time;
      logic [15:0] event_number;
      logic [1:0]  event_kind;
      logic        first_of_event;
      logic        last_of_event;
      logic        implied_valid;
      logic [7:0]  implied_status;
      logic [2:0]  error_code;
   } rsp_payload_type;

endpackage

`default_nettype wire

@@ design/midi_track_event_parser.sv @@
// ----------------------------------------------------------------------------
// midi_track_event_parser
// splits the bytes of a midi track chunk into events, one byte per transfer
// ----------------------------------------------------------------------------
// an accepted byte's result, if it has one, goes to the output register, or to the skid register while that is held
// throughput: one byte per cycle while req_stall is low; the whole parse step sits in one register stage
// req_stall rises only while the skid register holds a result that found the
// output register occupied, and falls once that result moves on
// reset (synchronous) clears the parser state, the event count and both valids
`default_nettype none

module midi_track_event_parser #(
   parameter int EVENT_COUNT_BITS = mtep_pkg::EVENT_COUNT_BITS
) (
   input  wire                         clock,
   input  wire                         reset,
   // byte input
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire mtep_pkg::req_payload_type req_data,
   // event byte output
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output mtep_pkg::rsp_payload_type   rsp_data
);

   // bits of the count that reach event_number
   localparam int NumW = (EVENT_COUNT_BITS < 16) ? EVENT_COUNT_BITS : 16;

   // parser state
   mtep_pkg::phase_type         phase_ff, phase_in;
   logic [7:0]                  run_status_ff, run_status_in;
   logic [27:0]                 delta_acc_ff, delta_acc_in;
   logic [1:0]                  vlv_seen_ff, vlv_seen_in;
   logic [27:0]                 len_acc_ff, len_acc_in;
   logic [28:0]                 bytes_left_ff, bytes_left_in;
   logic [EVENT_COUNT_BITS-1:0] event_count_ff, event_count_in;
   logic [1:0]                  kind_ff, kind_in;

   // output register and skid register
   logic                        out_valid_ff, out_valid_in;
   mtep_pkg::rsp_payload_type   out_data_ff, out_data_in;
   logic                        skid_valid_ff, skid_valid_in;
   mtep_pkg::rsp_payload_type   skid_data_ff, skid_data_in;

   // handshake
   logic                        req_take;
   logic                        rsp_take;

   // parse step results
   logic                        res_valid;
   mtep_pkg::rsp_payload_type   res_data;

   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   // ------------------------------------------------------------------
   // parse step: one byte against the current state
   // ------------------------------------------------------------------
   always_comb begin
      logic [7:0]                  b;
      mtep_pkg::phase_type         cur_phase;
      logic [7:0]                  cur_rs;
      logic [1:0]                  cur_seen;
      logic [1:0]                  cur_kind;
      logic [EVENT_COUNT_BITS-1:0] cur_count;
      logic [27:0]                 delta_new;
      logic [27:0]                 len_new;
      logic                        vlv_over;
      logic [28:0]                 left_dec;
      logic                        is_chan3;
      logic                        is_chan2;
      logic                        rs_chan2;
      logic                        emit;
      logic                        done;
      logic [2:0]                  err;
      logic                        fo;
      logic                        lo;
      logic                        iv;
      logic [7:0]                  istat;

      b = req_data.in_byte;

      // start of a track restarts the parse before the byte is looked at
      cur_phase = req_data.track_first ? mtep_pkg::PH_DELTA : phase_ff;
      cur_rs    = req_data.track_first ? 8'd0 : run_status_ff;
      cur_seen  = req_data.track_first ? 2'd0 : vlv_seen_ff;
      cur_kind  = req_data.track_first ? mtep_pkg::KIND_CHAN3 : kind_ff;
      cur_count = req_data.track_first ? '0 : event_count_ff;

      phase_in       = cur_phase;
      run_status_in  = cur_rs;
      delta_acc_in   = req_data.track_first ? 28'd0 : delta_acc_ff;
      vlv_seen_in    = cur_seen;
      len_acc_in     = req_data.track_first ? 28'd0 : len_acc_ff;
      bytes_left_in  = req_data.track_first ? 29'd0 : bytes_left_ff;
      kind_in        = cur_kind;
      event_count_in = cur_count;

      // seven payload bits shifted onto the accumulator (fresh on the first byte)
      delta_new = {((cur_seen != 2'd0) ? delta_acc_ff[20:0] : 21'd0),
                   b[6:0] & mtep_pkg::VLV_PAYLOAD[6:0]};
      len_new   = {((cur_seen != 2'd0) ? len_acc_ff[20:0] : 21'd0),
                   b[6:0] & mtep_pkg::VLV_PAYLOAD[6:0]};
      vlv_over  = b[7] && (({1'b0, cur_seen} + 3'd1) >= 3'(mtep_pkg::VLV_MAX_BYTES));
      left_dec  = bytes_left_in - 29'd1;

      is_chan3 = ((b >= mtep_pkg::CHAN3_LO) && (b <= mtep_pkg::CHAN3_HI)) ||
                 ((b >= mtep_pkg::PITCH_LO) && (b <= mtep_pkg::PITCH_HI));
      is_chan2 = (b >= mtep_pkg::CHAN2_LO) && (b <= mtep_pkg::CHAN2_HI);
      rs_chan2 = (cur_rs >= mtep_pkg::CHAN2_LO) && (cur_rs <= mtep_pkg::CHAN2_HI);

      emit  = 1'b0;
      done  = 1'b0;
      err   = mtep_pkg::ERR_NONE;
      fo    = 1'b0;
      lo    = 1'b0;
      iv    = 1'b0;
      istat = 8'd0;

      case (cur_phase)
         mtep_pkg::PH_DELTA: begin
            delta_acc_in = delta_new;
            if (b[7]) begin
               if (vlv_over) begin
                  err = mtep_pkg::ERR_VLV_LONG;
               end else begin
                  vlv_seen_in = cur_seen + 2'd1;
               end
            end else begin
               vlv_seen_in = 2'd0;
               phase_in    = mtep_pkg::PH_STATUS;
            end
         end
         mtep_pkg::PH_STATUS: begin
            emit = 1'b1;
            fo   = 1'b1;
            if (is_chan3) begin
               kind_in       = mtep_pkg::KIND_CHAN3;
               run_status_in = b;
               bytes_left_in = 29'd2;
               phase_in      = mtep_pkg::PH_DATA;
            end else if (is_chan2) begin
               kind_in       = mtep_pkg::KIND_CHAN2;
               run_status_in = b;
               bytes_left_in = 29'd1;
               phase_in      = mtep_pkg::PH_DATA;
            end else if (b == mtep_pkg::META_STATUS) begin
               kind_in       = mtep_pkg::KIND_META;
               run_status_in = 8'd0;
               phase_in      = mtep_pkg::PH_MTYPE;
            end else if ((b == mtep_pkg::SYSEX_START) || (b == mtep_pkg::SYSEX_ESC)) begin
               kind_in       = mtep_pkg::KIND_SYSEX;
               run_status_in = 8'd0;
               vlv_seen_in   = 2'd0;
               phase_in      = mtep_pkg::PH_LEN;
            end else if (b <= mtep_pkg::DATA_MAX) begin
               // data byte in status position: running status
               if (cur_rs != 8'd0) begin
                  kind_in = rs_chan2 ? mtep_pkg::KIND_CHAN2 : mtep_pkg::KIND_CHAN3;
                  iv      = 1'b1;
                  istat   = cur_rs;
                  if (rs_chan2) begin
                     lo   = 1'b1;
                     done = 1'b1;
                  end else begin
                     bytes_left_in = 29'd1;
                     phase_in      = mtep_pkg::PH_DATA;
                  end
               end else begin
                  err = mtep_pkg::ERR_NO_RUNNING;
               end
            end else begin
               err = mtep_pkg::ERR_BAD_STATUS;
            end
         end
         mtep_pkg::PH_MTYPE: begin
            emit        = 1'b1;
            vlv_seen_in = 2'd0;
            phase_in    = mtep_pkg::PH_LEN;
         end
         mtep_pkg::PH_LEN: begin
            emit       = 1'b1;
            len_acc_in = len_new;
            if (b[7]) begin
               if (vlv_over) begin
                  err = mtep_pkg::ERR_VLV_LONG;
               end else begin
                  vlv_seen_in = cur_seen + 2'd1;
               end
            end else begin
               vlv_seen_in = 2'd0;
               if (len_new == 28'd0) begin
                  // empty meta or sysex ends on its length
                  lo   = 1'b1;
                  done = 1'b1;
               end else begin
                  bytes_left_in = {1'b0, len_new};
                  phase_in      = mtep_pkg::PH_DATA;
               end
            end
         end
         mtep_pkg::PH_DATA: begin
            emit          = 1'b1;
            bytes_left_in = left_dec;
            if (left_dec == 29'd0) begin
               lo   = 1'b1;
               done = 1'b1;
            end
         end
         default: begin
            phase_in    = mtep_pkg::PH_DELTA;
            vlv_seen_in = 2'd0;
         end
      endcase

      // track ends inside an event
      if ((err == mtep_pkg::ERR_NONE) && req_data.track_last && !done) begin
         err = mtep_pkg::ERR_TRUNCATED;
      end

      res_data.out_byte     = b;
      res_data.event_number = 16'(cur_count[NumW-1:0]);
      res_data.error_code   = err;

      if (err != mtep_pkg::ERR_NONE) begin
         // pass the byte on with its error code and look for a fresh delta time
         phase_in                = mtep_pkg::PH_DELTA;
         vlv_seen_in             = 2'd0;
         res_valid               = 1'b1;
         res_data.delta_time     = 28'd0;
         res_data.event_kind     = mtep_pkg::KIND_CHAN3;
         res_data.first_of_event = 1'b0;
         res_data.last_of_event  = 1'b0;
         res_data.implied_valid  = 1'b0;
         res_data.implied_status = 8'd0;
      end else begin
         res_valid               = emit;
         res_data.delta_time     = delta_acc_in;
         res_data.event_kind     = kind_in;
         res_data.first_of_event = fo;
         res_data.last_of_event  = lo;
         res_data.implied_valid  = iv;
         res_data.implied_status = istat;
         if (done) begin
            phase_in = mtep_pkg::PH_DELTA;
            // saturating event count
            if (!(&cur_count)) begin
               event_count_in = cur_count + EVENT_COUNT_BITS'(1);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // output register with skid stage
   // ------------------------------------------------------------------
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;

      if (skid_valid_ff) begin
         // input is stalled; move the held result on once there is room
         if (!out_valid_ff || rsp_take) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take && res_valid) begin
         if (!out_valid_ff || rsp_take) begin
            out_valid_in = 1'b1;
            out_data_in  = res_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res_data;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= mtep_pkg::PH_DELTA;
         run_status_ff  <= 8'd0;
         delta_acc_ff   <= 28'd0;
         vlv_seen_ff    <= 2'd0;
         len_acc_ff     <= 28'd0;
         bytes_left_ff  <= 29'd0;
         event_count_ff <= '0;
         kind_ff        <= mtep_pkg::KIND_CHAN3;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (req_take) begin
            phase_ff       <= phase_in;
            run_status_ff  <= run_status_in;
            delta_acc_ff   <= delta_acc_in;
            vlv_seen_ff    <= vlv_seen_in;
            len_acc_ff     <= len_acc_in;
            bytes_left_ff  <= bytes_left_in;
            event_count_ff <= event_count_in;
            kind_ff        <= kind_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire
